[rtl/core/osst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osst_pkg
// shared widths, codes and defaults of the one-shot timer table
// ----------------------------------------------------------------------------
package osst_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int TIME_W         = 32;
	localparam int TICK_W         = 10;
	localparam int SLOT_IDX_W     = 6;

	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);

	// command opcodes
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// response kinds
	localparam logic KIND_SET    = 1'b0;
	localparam logic KIND_EXPIRE = 1'b1;

endpackage

`default_nettype wire

[rtl/core/osst_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osst_if
// valid/ready channels of the timer table: command in, response out
// ----------------------------------------------------------------------------
interface osst_cmd_if;
	import osst_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [TIME_W-1:0] duration_ms;

	modport source (output valid, output opcode, output duration_ms, input ready);
	modport sink   (input valid, input opcode, input duration_ms, output ready);
endinterface

interface osst_rsp_if;
	import osst_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic                  set_failed;
	logic                  last;

	modport source (output valid, output kind, output slot_index, output set_failed,
		output last, input ready);
	modport sink   (input valid, input kind, input slot_index, input set_failed,
		input last, output ready);
endinterface

`default_nettype wire

[rtl/core/one_shot_soft_timer_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_soft_timer_table
// table of one-shot millisecond timers with set and tick commands
// ----------------------------------------------------------------------------
// A set word claims the lowest idle slot, loads it with duration_ms and
// answers with the slot index (or set_failed when every slot is busy). A tick
// word walks all slots in index order: a busy slot with at least tick_ms left
// is decremented, any other busy slot is freed and reported as an expiry
// word, in index order, the final one with last set; a tick that frees
// nothing gives no word. The command side takes one word at a time. A set
// walks the busy flags one slot per cycle; its answer waits for a free
// response port. A tick skips idle slots; a busy slot gets a ram read, then
// compare and subtract with write-back in the shared unit, and a closing
// step ends the walk; a stalled response port holds the walk. The remaining
// times sit in a small ram with one read and one write port, whose registered
// read splits a busy slot into a read and a compare step. No clearing pass is
// needed after reset: a time is only read for a busy slot, and a slot only
// turns busy when its time is written. tick_ms resets to 10; the user writes
// it via cfg_we / cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module one_shot_soft_timer_table #(
	parameter int SLOT_COUNT = osst_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [osst_pkg::TICK_W-1:0]  cfg_wdata,
	osst_cmd_if.sink                          cmd,
	osst_rsp_if.source                        rsp
);
	import osst_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET,
		S_RD,
		S_EX,
		S_FLUSH
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        idx_q;
	logic [TIME_W-1:0]       dur_q;
	logic [TICK_W-1:0]       tick_q;
	logic [SLOT_COUNT-1:0]   busy_q;

	// one expiry held back until we know whether another follows
	logic                    pend_q;
	logic [IDX_W-1:0]        pend_idx_q;

	// response register
	logic                    rsp_valid_q;
	logic                    rsp_kind_q;
	logic [SLOT_IDX_W-1:0]   rsp_idx_q;
	logic                    rsp_fail_q;
	logic                    rsp_last_q;

	logic                    rsp_free;
	logic                    rsp_push;
	logic                    idx_is_last;
	logic [TIME_W-1:0]       ram_rdata;
	logic [TIME_W-1:0]       sub_diff;
	logic                    sub_ge;
	logic                    ram_we;
	logic [TIME_W-1:0]       ram_wdata;

	assign rsp_free    = ~rsp_valid_q | rsp.ready;
	assign idx_is_last = (idx_q == IDX_LAST);

	assign cmd.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.kind       = rsp_kind_q;
	assign rsp.slot_index = rsp_idx_q;
	assign rsp.set_failed = rsp_fail_q;
	assign rsp.last       = rsp_last_q;

	// ram write: load on a successful set, write-back of a decremented time
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = sub_diff;
		if (state_q == S_SET && !busy_q[idx_q] && rsp_free) begin
			ram_we    = 1'b1;
			ram_wdata = dur_q;
		end else if (state_q == S_EX && sub_ge) begin
			ram_we = 1'b1;
		end
	end

	// a new response word is loaded this cycle
	always_comb begin
		rsp_push = 1'b0;
		case (state_q)
			S_SET:   rsp_push = rsp_free && (!busy_q[idx_q] || idx_is_last);
			S_EX:    rsp_push = rsp_free && !sub_ge && pend_q;
			S_FLUSH: rsp_push = rsp_free && pend_q;
			default: rsp_push = 1'b0;
		endcase
	end

	osst_ram #(
		.WIDTH (TIME_W),
		.DEPTH (SLOT_COUNT)
	) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	osst_sub u_sub (
		.time_left (ram_rdata),
		.tick      (tick_q),
		.diff      (sub_diff),
		.no_borrow (sub_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			tick_q      <= TICK_RESET;
			busy_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response register: load a new word, else drain
			if (rsp_push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						idx_q <= '0;
						dur_q <= cmd.duration_ms;
						state_q <= (cmd.opcode == OP_SET) ? S_SET : S_RD;
					end
				end

				// search for the lowest idle slot, one per cycle
				S_SET: begin
					if (!busy_q[idx_q]) begin
						if (rsp_free) begin
							busy_q[idx_q] <= 1'b1;
							rsp_kind_q    <= KIND_SET;
							rsp_idx_q     <= SLOT_IDX_W'(idx_q);
							rsp_fail_q    <= 1'b0;
							rsp_last_q    <= 1'b1;
							state_q       <= S_IDLE;
						end
					end else if (idx_is_last) begin
						// table full
						if (rsp_free) begin
							rsp_kind_q  <= KIND_SET;
							rsp_idx_q   <= '0;
							rsp_fail_q  <= 1'b1;
							rsp_last_q  <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end

				// idle slots are skipped, busy ones get their time read
				S_RD: begin
					if (busy_q[idx_q]) begin
						state_q <= S_EX;
					end else if (idx_is_last) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end

				S_EX: begin
					if (sub_ge || !pend_q || rsp_free) begin
						if (!sub_ge) begin
							// expiry: push the held one out, hold this one
							if (pend_q) begin
								rsp_kind_q  <= KIND_EXPIRE;
								rsp_idx_q   <= SLOT_IDX_W'(pend_idx_q);
								rsp_fail_q  <= 1'b0;
								rsp_last_q  <= 1'b0;
							end
							pend_q        <= 1'b1;
							pend_idx_q    <= idx_q;
							busy_q[idx_q] <= 1'b0;
						end
						if (idx_is_last) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end

				// close the walk: the held expiry is the final word
				S_FLUSH: begin
					if (!pend_q) begin
						state_q <= S_IDLE;
					end else if (rsp_free) begin
						rsp_kind_q  <= KIND_EXPIRE;
						rsp_idx_q   <= SLOT_IDX_W'(pend_idx_q);
						rsp_fail_q  <= 1'b0;
						rsp_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

[rtl/core/osst_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osst_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module osst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

[rtl/core/osst_sub.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osst_sub
// shared compare and subtract unit: remaining time minus tick size
// ----------------------------------------------------------------------------
module osst_sub (
	input  wire logic [osst_pkg::TIME_W-1:0] time_left,
	input  wire logic [osst_pkg::TICK_W-1:0] tick,
	output logic      [osst_pkg::TIME_W-1:0] diff,
	output logic                             no_borrow
);
	import osst_pkg::*;

	logic [TIME_W:0] wide;

	// borrow out of the extended subtract means time_left < tick
	assign wide      = {1'b0, time_left} - {{(TIME_W + 1 - TICK_W){1'b0}}, tick};
	assign diff      = wide[TIME_W-1:0];
	assign no_borrow = ~wide[TIME_W];
endmodule

`default_nettype wire
